/* rtl/mdm_pkg.sv */
// Shared widths, payload types and helpers for the mecanum drive mixer.
// No dependencies; every other file in rtl/ uses this package.
package mdm_pkg;

    localparam int SPD_W   = 9;            // speed and drive width
    localparam int SUM_W   = 11;           // wheel sum, +/-768 max
    localparam int MAG_W   = 10;           // |sum|, up to 768
    localparam int LIM_W   = 8;            // drive limit register
    localparam int NUM_W   = MAG_W + LIM_W; // |sum| * limit
    localparam int Q_W     = 8;            // quotient magnitude, <= limit
    localparam int N_WHEEL = 4;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd255;

    // Wheel order: front-left, front-right, back-right, back-left
    localparam int FL = 0;
    localparam int FR = 1;
    localparam int BR = 2;
    localparam int BL = 3;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [NUM_W-1:0] rem;   // partial remainder
        logic [Q_W-1:0]   quo;   // quotient magnitude built so far
        logic             neg;   // wheel sum was negative
    } t_lane;

    typedef struct packed {
        t_lane [N_WHEEL-1:0] lane;
        logic [MAG_W-1:0]    div;    // peak when scaling, else 1
        logic                scaled;
    } t_div_word;

    function automatic logic [MAG_W-1:0] sum_mag(input t_sum v);
        t_sum a;
        a = (v < 0) ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic [SPD_W-1:0] drive_mag(input logic signed [SPD_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

/* rtl/mdm_front.sv */
// Front end of the mixer: wheel sums, peak search, numerator select.
// Three register stages with per-stage ready; uses mdm_pkg.
module mdm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [mdm_pkg::SPD_W-1:0]   i_fwd,
    input  logic signed [mdm_pkg::SPD_W-1:0]   i_side,
    input  logic signed [mdm_pkg::SPD_W-1:0]   i_rot,
    input  logic        [mdm_pkg::LIM_W-1:0]   i_limit,
    output logic                               o_valid,
    input  logic                               i_ready,
    output mdm_pkg::t_div_word                 o_word
);

    // stage A: sums
    logic              r_a_valid;
    mdm_pkg::t_sum     r_a_sum [mdm_pkg::N_WHEEL];
    mdm_pkg::t_sum     n_a_sum [mdm_pkg::N_WHEEL];
    // stage B: magnitudes and peak
    logic                           r_b_valid;
    logic [mdm_pkg::MAG_W-1:0]      r_b_mag [mdm_pkg::N_WHEEL];
    logic [mdm_pkg::N_WHEEL-1:0]    r_b_neg;
    logic [mdm_pkg::MAG_W-1:0]      r_b_peak;
    logic                           r_b_scaled;
    logic [mdm_pkg::MAG_W-1:0]      n_b_mag [mdm_pkg::N_WHEEL];
    logic [mdm_pkg::MAG_W-1:0]      w_m01, w_m23, n_b_peak;
    // stage C: divider operands
    logic                           r_c_valid;
    mdm_pkg::t_div_word             r_c_word;
    mdm_pkg::t_div_word             n_c_word;

    logic w_rdy_a, w_rdy_b, w_rdy_c;

    assign w_rdy_c = !r_c_valid || i_ready;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign w_rdy_a = !r_a_valid || w_rdy_b;
    assign o_ready = w_rdy_a;
    assign o_valid = r_c_valid;
    assign o_word  = r_c_word;

    always_comb begin
        mdm_pkg::t_sum a, b, c;
        a = mdm_pkg::t_sum'(i_fwd);
        b = mdm_pkg::t_sum'(i_side);
        c = mdm_pkg::t_sum'(i_rot);
        n_a_sum[mdm_pkg::FL] = a + b + c;
        n_a_sum[mdm_pkg::FR] = a - b - c;
        n_a_sum[mdm_pkg::BR] = a + b - c;
        n_a_sum[mdm_pkg::BL] = a - b + c;
    end

    always_comb begin
        for (int k = 0; k < mdm_pkg::N_WHEEL; k++) begin
            n_b_mag[k] = mdm_pkg::sum_mag(r_a_sum[k]);
        end
        w_m01    = (n_b_mag[0] > n_b_mag[1]) ? n_b_mag[0] : n_b_mag[1];
        w_m23    = (n_b_mag[2] > n_b_mag[3]) ? n_b_mag[2] : n_b_mag[3];
        n_b_peak = (w_m01 > w_m23) ? w_m01 : w_m23;
    end

    always_comb begin
        n_c_word.scaled = r_b_scaled;
        n_c_word.div    = r_b_scaled ? r_b_peak : mdm_pkg::MAG_W'(1);
        for (int k = 0; k < mdm_pkg::N_WHEEL; k++) begin
            n_c_word.lane[k].quo = '0;
            n_c_word.lane[k].neg = r_b_neg[k];
            // unscaled: |sum| / 1 returns |sum| itself
            n_c_word.lane[k].rem = r_b_scaled
                ? mdm_pkg::NUM_W'(r_b_mag[k]) * mdm_pkg::NUM_W'(i_limit)
                : mdm_pkg::NUM_W'(r_b_mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_valid <= i_valid;
            if (w_rdy_b) r_b_valid <= r_a_valid;
            if (w_rdy_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_sum <= n_a_sum;
        end
        if (w_rdy_b) begin
            r_b_mag    <= n_b_mag;
            r_b_peak   <= n_b_peak;
            r_b_scaled <= n_b_peak > mdm_pkg::MAG_W'(i_limit);
            for (int k = 0; k < mdm_pkg::N_WHEEL; k++) begin
                r_b_neg[k] <= r_a_sum[k] < 0;
            end
        end
        if (w_rdy_c) begin
            r_c_word <= n_c_word;
        end
    end

`ifndef SYNTHESIS
    a_scaled_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_word.scaled |-> r_c_word.div > mdm_pkg::MAG_W'(i_limit))
        else $error("scaled item with peak not above limit");
    a_unscaled_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !r_c_word.scaled |-> r_c_word.div == mdm_pkg::MAG_W'(1))
        else $error("unscaled item with divisor other than one");
`endif

endmodule

/* rtl/mdm_div.sv */
// Pipelined restoring divider, four wheel lanes sharing one divisor.
// Two quotient bits per stage; uses mdm_pkg.
module mdm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mdm_pkg::t_div_word i_word,
    output logic               o_valid,
    input  logic               i_ready,
    output mdm_pkg::t_div_word o_word
);

    localparam int LAST = mdm_pkg::DIV_STAGES - 1;

    logic [mdm_pkg::DIV_STAGES-1:0] r_v;
    mdm_pkg::t_div_word             r_word [mdm_pkg::DIV_STAGES];
    mdm_pkg::t_div_word             w_src  [mdm_pkg::DIV_STAGES];
    mdm_pkg::t_div_word             n_word [mdm_pkg::DIV_STAGES];
    logic [mdm_pkg::DIV_STAGES-1:0] w_vsrc;
    logic [mdm_pkg::DIV_STAGES:0]   w_rdy;

    always_comb begin
        w_src[0]  = i_word;
        w_vsrc[0] = i_valid;
        for (int s = 1; s < mdm_pkg::DIV_STAGES; s++) begin
            w_src[s]  = r_word[s-1];
            w_vsrc[s] = r_v[s-1];
        end
        w_rdy[mdm_pkg::DIV_STAGES] = i_ready;
        for (int s = LAST; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end

    // compare-subtract of divisor << bit, from the top quotient bit down
    always_comb begin
        logic [mdm_pkg::NUM_W-1:0] shifted;
        shifted = '0;
        for (int s = 0; s < mdm_pkg::DIV_STAGES; s++) begin
            n_word[s] = w_src[s];
            for (int b = 0; b < mdm_pkg::BITS_PER_STAGE; b++) begin
                for (int k = 0; k < mdm_pkg::N_WHEEL; k++) begin
                    shifted = mdm_pkg::NUM_W'(n_word[s].div)
                        << (mdm_pkg::Q_W - 1 - s * mdm_pkg::BITS_PER_STAGE - b);
                    if (n_word[s].lane[k].rem >= shifted) begin
                        n_word[s].lane[k].rem = n_word[s].lane[k].rem - shifted;
                        n_word[s].lane[k].quo[mdm_pkg::Q_W - 1
                            - s * mdm_pkg::BITS_PER_STAGE - b] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < mdm_pkg::DIV_STAGES; s++) begin
                if (w_rdy[s]) r_v[s] <= w_vsrc[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < mdm_pkg::DIV_STAGES; s++) begin
            if (w_rdy[s]) r_word[s] <= n_word[s];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[LAST];
    assign o_word  = r_word[LAST];

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> r_word[0].div != '0)
        else $error("zero divisor in divider");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |->
            mdm_pkg::NUM_W'(r_word[LAST].div) > r_word[LAST].lane[0].rem &&
            mdm_pkg::NUM_W'(r_word[LAST].div) > r_word[LAST].lane[1].rem &&
            mdm_pkg::NUM_W'(r_word[LAST].div) > r_word[LAST].lane[2].rem &&
            mdm_pkg::NUM_W'(r_word[LAST].div) > r_word[LAST].lane[3].rem)
        else $error("final remainder not below divisor");
`endif

endmodule

/* rtl/mecanum_drive_mixer.sv */
// Top level of the mecanum drive mixer: limit register, front end,
// divider and the signed output register. Uses mdm_pkg, mdm_front, mdm_div.
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ------------------------------------
//  s_axis    in   i_s_axis_tvalid/tready  tdata: fwd, side, rot (9b each)
//  m_axis    out  o_m_axis_tvalid/tready  tdata: fl, fr, br, bl; tuser: scaled
//  cfg       in   i_cfg_we                i_cfg_wdata: drive limit
//
// One transfer per cycle sustained when the output is not stalled. Eight
// register stages: three front stages (mix, peak, numerator), four divider
// stages at two quotient bits each and one output stage.
// Each stage has its own valid and ready, so bubbles close up and a stall
// at the output holds every loaded stage without loss.
// Synchronous active-low reset clears all valids and sets the limit to 255.
module mecanum_drive_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [8:0] forward_speed, [17:9] sideways_speed, [26:18] rotation_speed
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [8:0] front_left, [17:9] front_right, [26:18] back_right,
    // [35:27] back_left drive
    output logic [39:0] o_m_axis_tdata,
    // [0] was_scaled
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int W = mdm_pkg::SPD_W;

    logic [mdm_pkg::LIM_W-1:0] r_limit;

    logic               w_front_valid, w_front_ready;
    mdm_pkg::t_div_word w_front_word;
    logic               w_div_valid, w_out_ready;
    mdm_pkg::t_div_word w_div_word;

    logic                       r_out_valid;
    logic signed [W-1:0]        r_drive [mdm_pkg::N_WHEEL];
    logic signed [W-1:0]        n_drive [mdm_pkg::N_WHEEL];
    logic                       r_scaled;

    // drive limit, both threshold and scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mdm_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    mdm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_fwd   ($signed(i_s_axis_tdata[W-1:0])),
        .i_side  ($signed(i_s_axis_tdata[2*W-1:W])),
        .i_rot   ($signed(i_s_axis_tdata[3*W-1:2*W])),
        .i_limit (r_limit),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready),
        .o_word  (w_front_word)
    );

    mdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_word  (w_front_word),
        .o_valid (w_div_valid),
        .i_ready (w_out_ready),
        .o_word  (w_div_word)
    );

    assign w_out_ready = !r_out_valid || i_m_axis_tready;

    // floor for negative sums: -(q + 1) when the division left a remainder
    always_comb begin
        logic [W-1:0] q;
        q = '0;
        for (int k = 0; k < mdm_pkg::N_WHEEL; k++) begin
            q = W'(w_div_word.lane[k].quo)
                + W'(w_div_word.lane[k].rem != '0 && w_div_word.lane[k].neg);
            n_drive[k] = w_div_word.lane[k].neg ? -$signed(q) : $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_drive  <= n_drive;
            r_scaled <= w_div_word.scaled;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000,
                              r_drive[mdm_pkg::BL], r_drive[mdm_pkg::BR],
                              r_drive[mdm_pkg::FR], r_drive[mdm_pkg::FL]};
    assign o_m_axis_tuser  = r_scaled;

`ifndef SYNTHESIS
    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            mdm_pkg::drive_mag(r_drive[0]) <= W'(r_limit) &&
            mdm_pkg::drive_mag(r_drive[1]) <= W'(r_limit) &&
            mdm_pkg::drive_mag(r_drive[2]) <= W'(r_limit) &&
            mdm_pkg::drive_mag(r_drive[3]) <= W'(r_limit))
        else $error("drive magnitude above limit");
    a_peak_hits_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_scaled |->
            mdm_pkg::drive_mag(r_drive[0]) == W'(r_limit) ||
            mdm_pkg::drive_mag(r_drive[1]) == W'(r_limit) ||
            mdm_pkg::drive_mag(r_drive[2]) == W'(r_limit) ||
            mdm_pkg::drive_mag(r_drive[3]) == W'(r_limit))
        else $error("scaled item without a wheel at the limit");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for mecanum_drive_mixer: random and directed speed
// commands, drive-limit phases, and random stalls on both stream sides.
// Depends on rtl/mdm_pkg.sv and rtl/mecanum_drive_mixer.sv.
module testbench;

    import mdm_pkg::*;

    // Drain wait after the last result: covers the pipeline plus margin
    localparam int DRAIN_CYCLES     = 16;
    // Idle cycles before a limit write, covers the full pipeline
    localparam int CFG_SETTLE       = 12;
    // Cycles with no transfer and no limit write before the run is declared hung
    localparam int WATCHDOG_LIMIT   = 200;
    localparam int ITEMS_PER_PHASE  = 160;
    localparam int NUM_PHASES       = 8;

    typedef logic signed [SPD_W-1:0] speed_t;

    // One predicted result, plus the command that caused it for the log
    typedef struct {
        speed_t            fl;
        speed_t            fr;
        speed_t            br;
        speed_t            bl;
        logic              scaled;
        logic [3*SPD_W-1:0] cmd;
    } wheel_drives_t;

    // Tracks the drive limit, predicts each wheel result in order and
    // compares it with what the block returns.
    class mixer_scoreboard;
        logic [LIM_W-1:0] drive_limit;
        wheel_drives_t    expected_drives[$];
        int               errors;

        function new();
            drive_limit = LIMIT_RESET;
            errors      = 0;
        endfunction

        function void set_limit(logic [LIM_W-1:0] value);
            drive_limit = value;
        endfunction

        // Mix, find the peak and scale with a flooring divide when the
        // peak is above the limit.
        function wheel_drives_t mix_wheels(speed_t fwd, speed_t side, speed_t rot);
            wheel_drives_t res;
            int            sum[N_WHEEL];
            int            peak;
            int            lim;
            int            prod;
            int            q;
            int            mag;
            sum[FL] = int'(fwd) + int'(side) + int'(rot);
            sum[FR] = int'(fwd) - int'(side) - int'(rot);
            sum[BR] = int'(fwd) + int'(side) - int'(rot);
            sum[BL] = int'(fwd) - int'(side) + int'(rot);
            lim  = int'(drive_limit);
            peak = 0;
            for (int i = 0; i < N_WHEEL; i++) begin
                mag = (sum[i] < 0) ? -sum[i] : sum[i];
                if (mag > peak) begin
                    peak = mag;
                end
            end
            res.scaled = (peak > lim);
            if (res.scaled) begin
                for (int i = 0; i < N_WHEEL; i++) begin
                    prod = sum[i] * lim;
                    q    = prod / peak;
                    // SV divide truncates; step down for negative remainders
                    if ((prod % peak) != 0 && prod < 0) begin
                        q = q - 1;
                    end
                    sum[i] = q;
                end
            end
            res.fl  = sum[FL][SPD_W-1:0];
            res.fr  = sum[FR][SPD_W-1:0];
            res.br  = sum[BR][SPD_W-1:0];
            res.bl  = sum[BL][SPD_W-1:0];
            res.cmd = {rot, side, fwd};
            return res;
        endfunction

        function void note_command(logic [31:0] tdata);
            expected_drives.push_back(mix_wheels(tdata[SPD_W-1:0],
                                                 tdata[2*SPD_W-1:SPD_W],
                                                 tdata[3*SPD_W-1:2*SPD_W]));
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(string name, int got, int want, logic [3*SPD_W-1:0] cmd);
            if (got != want) begin
                report($sformatf("%s got %0d want %0d (fwd %0d side %0d rot %0d, limit %0d)",
                                 name, got, want,
                                 speed_t'(cmd[SPD_W-1:0]),
                                 speed_t'(cmd[2*SPD_W-1:SPD_W]),
                                 speed_t'(cmd[3*SPD_W-1:2*SPD_W]), drive_limit));
            end
        endtask

        task check_drives(logic [39:0] tdata, logic [0:0] tuser);
            wheel_drives_t want;
            if (expected_drives.size() == 0) begin
                report($sformatf("unexpected result tdata %h tuser %b", tdata, tuser));
            end else begin
                want = expected_drives.pop_front();
                check_field("front_left",  speed_t'(tdata[8:0]),   want.fl, want.cmd);
                check_field("front_right", speed_t'(tdata[17:9]),  want.fr, want.cmd);
                check_field("back_right",  speed_t'(tdata[26:18]), want.br, want.cmd);
                check_field("back_left",   speed_t'(tdata[35:27]), want.bl, want.cmd);
                check_field("was_scaled",  int'(tuser[0]), int'(want.scaled), want.cmd);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;

    mixer_scoreboard board;
    // When set, that side runs back to back with no idle cycles
    bit src_steady;
    bit snk_steady;
    int idle_cycles;

    mecanum_drive_mixer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Speed picker: full-range patterns half the time, with zeros, extremes and
    // small values mixed in so sums land near the limit often.
    function automatic speed_t pick_speed();
        speed_t extremes[5] = '{-9'sd256, -9'sd255, -9'sd1, 9'sd1, 9'sd255};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return extremes[$urandom_range(0, 4)];
            2, 3:    return speed_t'($urandom_range(0, 127) - 64);
            default: return speed_t'($urandom());
        endcase
    endfunction

    // Presents one command, entered and left at a falling edge. Valid is
    // only lowered when a gap is drawn, so it never toggles twice in a step.
    task automatic send_command(speed_t fwd, speed_t side, speed_t rot);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {5'b0, rot, side, fwd};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_command(i_s_axis_tdata);
        @(negedge i_clk);
    endtask

    // Limit writes only happen with the pipeline empty and the source idle.
    task automatic write_limit(logic [7:0] value);
        i_s_axis_tvalid = 1'b0;
        while (board.expected_drives.size() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_limit(value);
    endtask

    // Directed set at the reset limit of 255: zero command, single-axis
    // extremes, the most negative speed, largest sums, peak exactly at the
    // limit and one above it, and negative results that need floor rounding.
    task automatic run_directed();
        send_command(9'sd0, 9'sd0, 9'sd0);
        send_command(9'sd255, 9'sd0, 9'sd0);
        send_command(-9'sd255, 9'sd0, 9'sd0);
        send_command(-9'sd256, 9'sd0, 9'sd0);
        send_command(9'sd0, 9'sd255, 9'sd0);
        send_command(9'sd0, 9'sd0, -9'sd256);
        send_command(9'sd255, 9'sd255, 9'sd255);
        send_command(-9'sd256, -9'sd256, -9'sd256);
        send_command(-9'sd256, 9'sd255, -9'sd256);
        send_command(9'sd1, -9'sd1, 9'sd1);
        send_command(9'sd100, 9'sd100, 9'sd55);
        send_command(9'sd100, 9'sd100, 9'sd56);
        send_command(-9'sd1, 9'sd0, 9'sd0);
        send_command(9'sd0, -9'sd256, 9'sd255);
        send_command(9'sd85, 9'sd85, 9'sd85);
        send_command(-9'sd86, -9'sd85, -9'sd85);
        send_command(9'sd3, -9'sd2, 9'sd7);
        send_command(9'sd255, -9'sd256, 9'sd255);
    endtask

    // Result side: random ready gaps, stretches of steady ready, checks
    // every accepted transfer. Runs until the end of the test.
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                snk_steady = !snk_steady;
            end
            gap = snk_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            board.check_drives(o_m_axis_tdata, o_m_axis_tuser);
            @(negedge i_clk);
        end
    end

    // Hang detection: any transfer or limit write restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] phase_limit[NUM_PHASES];
        board           = new();
        src_steady      = 1'b0;
        snk_steady      = 1'b0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;

        // Limit schedule: smallest nonzero, zero (everything nonzero scales
        // to zero), full scale, midpoint, two and three random values.
        phase_limit = '{8'd1, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0, 8'd2, 8'd0};
        phase_limit[4] = 8'($urandom_range(1, 255));
        phase_limit[5] = 8'($urandom_range(1, 255));
        phase_limit[7] = 8'($urandom_range(3, 254));

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(phase_limit[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // an all-zero command now and then: the no-scale corner
                // even when the limit is zero
                if ($urandom_range(0, 31) == 0) begin
                    send_command(9'sd0, 9'sd0, 9'sd0);
                end else begin
                    send_command(pick_speed(), pick_speed(), pick_speed());
                end
            end
        end

        i_s_axis_tvalid = 1'b0;
        while (board.expected_drives.size() != 0) @(negedge i_clk);
        // stray results after the last expected one still get flagged
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (board.errors == 0 && board.expected_drives.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
